FILE: hdl/dfa_pkg.sv
// Package for the table-driven automaton matcher: item and result payloads,
// item kinds, status codes and the controller state type. No dependencies.
`default_nettype none

package dfa_pkg;

	typedef enum logic [2:0] {
		KIND_ADD   = 3'd0,
		KIND_WRITE = 3'd1,
		KIND_MARK  = 3'd2,
		KIND_FEED  = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_MARK,
		ST_RESP
	} fsm_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] from_state;
		logic [7:0] to_state;
		logic [7:0] symbol;
		logic       final_value;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] new_state;
		logic [7:0] current_state;
		logic       accepted;
		logic       match_done;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/dfa_channels.sv
// Valid/ready channel interfaces of the automaton matcher: items, results and
// the start state write. Depends on dfa_pkg.
`default_nettype none

interface dfa_item_if;
	logic           valid;
	logic           ready;
	dfa_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dfa_result_if;
	logic             valid;
	logic             ready;
	dfa_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dfa_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module dfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/dfa_table_matcher.sv
// Top level of the table-driven automaton matcher: controller, state registers
// and the two memories. Depends on dfa_pkg, dfa_channels and dfa_ram.
`default_nettype none

// A byte-wide deterministic automaton whose transition table and final marks
// live in two synchronous RAMs. After reset the block sweeps both memories to
// zero, one table entry per cycle, and takes no item meanwhile; start state
// writes are taken at any time. One item is handled at a time. Adding a state,
// writing a transition or a final mark, and the unused kinds go from idle
// straight to the response state. A byte that is not the last first passes
// through the table read (walk state), ending a string through the final-mark
// read (mark state), and a last byte through both, the table read and then the
// final-mark read, whose address the table read sets. A result waiting at the
// output stalls the next one.
module dfa_table_matcher #(
	parameter int NUM_STATES    = 256,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	dfa_item_if.sink            items,
	dfa_result_if.source        results,
	dfa_cfg_if.sink             cfg
);

	import dfa_pkg::*;

	localparam int CAP    = (NUM_STATES < 256) ? NUM_STATES : 256;
	localparam int RW     = $clog2(CAP);
	localparam int AW     = $clog2(ALPHABET_SIZE);
	localparam int TA     = RW + AW;
	localparam int TDEPTH = 2 ** TA;
	localparam int FDEPTH = 2 ** RW;

	fsm_t st_q, st_d;

	logic [TA-1:0] clr_q;
	logic [8:0]    count_q;
	logic [7:0]    walk_q;
	logic [7:0]    start_q;
	logic          last_q;
	logic          ok_q;
	result_t       res_q;
	result_t       out_q;
	logic          ov_q;

	logic          tt_we;
	logic [TA-1:0] tt_waddr;
	logic [7:0]    tt_wdata;
	logic [TA-1:0] tt_raddr;
	logic [7:0]    tt_rdata;
	logic          fm_we;
	logic [RW-1:0] fm_waddr;
	logic          fm_wdata;
	logic [RW-1:0] fm_raddr;
	logic          fm_rdata;

	logic          item_acc;
	logic          slot_free;
	logic          from_ok;
	logic          to_ok;
	logic          sym_ok;
	logic          walk_ok;
	logic [7:0]    nxt;
	logic          nxt_ok;

	logic          res_load;
	result_t       res_d;
	logic          walk_load;
	logic [7:0]    walk_d;
	logic          ok_load;
	logic          ok_d;
	logic          count_inc;

	dfa_ram #(
		.WIDTH (8),
		.DEPTH (TDEPTH)
	) u_table (
		.clk   (clk),
		.we    (tt_we),
		.waddr (tt_waddr),
		.wdata (tt_wdata),
		.raddr (tt_raddr),
		.rdata (tt_rdata)
	);

	dfa_ram #(
		.WIDTH (1),
		.DEPTH (FDEPTH)
	) u_marks (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	assign items.ready = (st_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign item_acc    = items.valid & items.ready;
	assign slot_free   = ~ov_q | results.ready;

	assign from_ok = {1'b0, items.data.from_state} < count_q;
	assign to_ok   = {1'b0, items.data.to_state} < count_q;
	assign sym_ok  = {1'b0, items.data.symbol} < 9'(ALPHABET_SIZE);
	assign walk_ok = {1'b0, walk_q} < 9'(CAP);
	assign nxt     = ok_q ? tt_rdata : 8'd0;
	assign nxt_ok  = {1'b0, nxt} < 9'(CAP);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_q == {TA{1'b1}}) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_acc) begin
					unique case (items.data.kind)
						KIND_FEED: st_d = ST_WALK;
						KIND_END:  st_d = ST_MARK;
						default:   st_d = ST_RESP;
					endcase
				end
			end
			ST_WALK: st_d = last_q ? ST_MARK : ST_RESP;
			ST_MARK: st_d = ST_RESP;
			ST_RESP: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		tt_we     = 1'b0;
		tt_waddr  = {items.data.from_state[RW-1:0], items.data.symbol[AW-1:0]};
		tt_wdata  = items.data.to_state;
		tt_raddr  = {walk_q[RW-1:0], items.data.symbol[AW-1:0]};
		fm_we     = 1'b0;
		fm_waddr  = items.data.from_state[RW-1:0];
		fm_wdata  = items.data.final_value;
		fm_raddr  = walk_q[RW-1:0];
		res_load  = 1'b0;
		res_d     = '0;
		res_d.current_state = walk_q;
		walk_load = 1'b0;
		walk_d    = walk_q;
		ok_load   = 1'b0;
		ok_d      = 1'b0;
		count_inc = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				tt_we    = 1'b1;
				tt_waddr = clr_q;
				tt_wdata = 8'd0;
				fm_we    = 1'b1;
				fm_waddr = clr_q[TA-1:AW];
				fm_wdata = 1'b0;
			end
			ST_IDLE: begin
				if (item_acc) begin
					unique case (items.data.kind)
						KIND_ADD: begin
							res_load = 1'b1;
							if (count_q >= 9'(CAP)) begin
								res_d.status = STATUS_FULL;
							end else begin
								res_d.new_state = count_q[7:0];
								count_inc       = 1'b1;
							end
						end
						KIND_WRITE: begin
							res_load = 1'b1;
							if (from_ok && to_ok && sym_ok) begin
								tt_we = 1'b1;
							end else begin
								res_d.status = STATUS_RANGE;
							end
						end
						KIND_MARK: begin
							res_load = 1'b1;
							if (from_ok) begin
								fm_we = 1'b1;
							end else begin
								res_d.status = STATUS_RANGE;
							end
						end
						KIND_FEED: begin
							ok_load = 1'b1;
							ok_d    = walk_ok & sym_ok;
						end
						KIND_END: begin
							ok_load = 1'b1;
							ok_d    = walk_ok;
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			ST_WALK: begin
				walk_load = 1'b1;
				walk_d    = nxt;
				ok_load   = 1'b1;
				ok_d      = nxt_ok;
				fm_raddr  = nxt[RW-1:0];
				if (!last_q) begin
					res_load            = 1'b1;
					res_d.current_state = nxt;
				end
			end
			ST_MARK: begin
				res_load            = 1'b1;
				res_d.current_state = start_q;
				res_d.accepted      = ok_q & fm_rdata;
				res_d.match_done    = 1'b1;
				walk_load           = 1'b1;
				walk_d              = start_q;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			count_q <= 9'd1;
			walk_q  <= 8'd0;
			start_q <= 8'd0;
			ov_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + {{(TA-1){1'b0}}, 1'b1};
			end
			if (count_inc) begin
				count_q <= count_q + 9'd1;
			end
			if (cfg.valid && cfg.ready) begin
				start_q <= cfg.data;
				walk_q  <= cfg.data;
			end else if (walk_load) begin
				walk_q <= walk_d;
			end
			if (st_q == ST_RESP && slot_free) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			last_q <= items.data.last_byte;
		end
		if (ok_load) begin
			ok_q <= ok_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (st_q == ST_RESP && slot_free) begin
			out_q <= res_q;
		end
	end

	assign results.valid = ov_q;
	assign results.data  = out_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for dfa_table_matcher: drives item and start-state transactions,
// predicts each result with a behavioural automaton and checks every result transaction.
// Depends on dfa_pkg, the dfa_channels interfaces and the dfa_table_matcher RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dfa_pkg::*;

	localparam int          HALF_PERIOD    = 5;
	localparam int          STATE_LIMIT    = 256;
	localparam int          ALPHABET       = 256;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int          HOLD_CYCLES    = 80;
	localparam int          QUIET_LIMIT    = 200000;
	localparam int          MAX_PRINTED    = 40;
	localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

	class dfa_scoreboard;
		bit [7:0]    next_state_of [0:STATE_LIMIT*ALPHABET-1];
		bit          accepting [0:STATE_LIMIT-1];
		int unsigned states_in_use;
		logic [7:0]  walk;
		logic [7:0]  start;
		result_t     expected_q[$];
		int          errors;
		int          n_items;
		int          n_results;
		int          n_matches;
		int          n_accepts;
		int          n_range;
		int          n_full;

		function new();
			states_in_use = 1;
			walk = '0;
			start = '0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		function void set_start(logic [7:0] value);
			start = value;
			walk = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(item_t it);
			result_t r;
			r = '0;
			n_items++;
			case (it.kind)
				KIND_ADD: begin
					if (states_in_use >= STATE_LIMIT) begin
						r.status = STATUS_FULL;
					end else begin
						r.new_state = states_in_use[7:0];
						states_in_use++;
					end
				end
				KIND_WRITE: begin
					if (it.from_state >= states_in_use || it.to_state >= states_in_use ||
					    it.symbol >= ALPHABET) begin
						r.status = STATUS_RANGE;
					end else begin
						next_state_of[{it.from_state, it.symbol}] = it.to_state;
					end
				end
				KIND_MARK: begin
					if (it.from_state >= states_in_use)
						r.status = STATUS_RANGE;
					else
						accepting[it.from_state] = it.final_value;
				end
				KIND_FEED: begin
					walk = (it.symbol < ALPHABET) ? next_state_of[{walk, it.symbol}] : 8'd0;
					if (it.last_byte) begin
						r.accepted = accepting[walk];
						r.match_done = 1'b1;
						walk = start;
					end
				end
				KIND_END: begin
					r.accepted = accepting[walk];
					r.match_done = 1'b1;
					walk = start;
				end
				default: begin
				end
			endcase
			r.current_state = walk;
			if (r.status == STATUS_RANGE)
				n_range++;
			if (r.status == STATUS_FULL)
				n_full++;
			if (r.match_done)
				n_matches++;
			if (r.accepted)
				n_accepts++;
			expected_q = {expected_q, r};
		endfunction

		function void compare(string field, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d: %s is %0h, expected %0h",
					n_results, field, got, want));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h arrived with nothing expected", got));
				return;
			end
			want = expected_q.pop_front();
			n_results++;
			compare("status", 8'(got.status), 8'(want.status));
			compare("new_state", got.new_state, want.new_state);
			compare("current_state", got.current_state, want.current_state);
			compare("accepted", 8'(got.accepted), 8'(want.accepted));
			compare("match_done", 8'(got.match_done), 8'(want.match_done));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dfa_item_if   items_ch ();
	dfa_result_if results_ch ();
	dfa_cfg_if    cfg_ch ();

	dfa_table_matcher u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	dfa_scoreboard sb;
	item_t         item_q[$];
	int unsigned   built;
	logic [7:0]    symbol_set [0:3];
	bit            calm;
	bit            hold_req;
	int            holds_done;

	always #HALF_PERIOD clk = ~clk;

	task automatic drive_items();
		int gap_left;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (items_ch.valid && items_ch.ready)
				sb.note_item(items_ch.data);
			if (!items_ch.valid || items_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					items_ch.valid <= 1'b0;
				end else if (item_q.size() == 0) begin
					items_ch.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 5);
					items_ch.valid <= 1'b0;
				end else begin
					items_ch.valid <= 1'b1;
					items_ch.data <= item_q.pop_front();
				end
			end
		end
	endtask

	task automatic take_results();
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				sb.check_result(results_ch.data);
			if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				holds_done++;
				stall_left = HOLD_CYCLES - 1;
				results_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 5);
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	endtask

	task automatic write_start(input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_start(value);
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (item_q.size() != 0 || items_ch.valid || sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic item_t make_item(logic [2:0] kind, logic [7:0] from_state,
		logic [7:0] to_state, logic [7:0] symbol, logic final_value, logic last_byte);
		item_t it;
		it.kind = kind;
		it.from_state = from_state;
		it.to_state = to_state;
		it.symbol = symbol;
		it.final_value = final_value;
		it.last_byte = last_byte;
		return it;
	endfunction

	function automatic void queue_item(item_t it);
		if (it.kind == KIND_ADD && built < STATE_LIMIT)
			built++;
		item_q = {item_q, it};
	endfunction

	function automatic void pick_symbol_set();
		foreach (symbol_set[i])
			symbol_set[i] = 8'($urandom);
	endfunction

	function automatic logic [7:0] any_state();
		if ($urandom_range(0, 15) != 0)
			return 8'($urandom_range(0, built - 1));
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] any_symbol();
		if ($urandom_range(0, 6) != 0)
			return symbol_set[$urandom_range(0, 3)];
		return 8'($urandom);
	endfunction

	function automatic void queue_random(int count);
		item_t       it;
		int unsigned pick;
		for (int n = 0; n < count; n++) begin
			it = item_t'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				it.kind = KIND_ADD;
			end else if (pick < 28) begin
				it.kind = KIND_WRITE;
				it.from_state = any_state();
				it.to_state = any_state();
				it.symbol = any_symbol();
			end else if (pick < 36) begin
				it.kind = KIND_MARK;
				it.from_state = any_state();
			end else if (pick < 90) begin
				it.kind = KIND_FEED;
				it.symbol = any_symbol();
				it.last_byte = ($urandom_range(0, 3) == 0);
			end else if (pick < 95) begin
				it.kind = KIND_END;
			end else begin
				it.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
			end
			queue_item(it);
		end
	endfunction

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sb = new();
		built = 1;
		calm = 1'b0;
		hold_req = 1'b0;
		holds_done = 0;
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.data = '0;
		results_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		pick_symbol_set();
		fork
			drive_items();
			take_results();
		join_none
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_start(8'h00);

		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1));
		queue_item(make_item(KIND_END, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_MARK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
		queue_item(make_item(KIND_END, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'hA5, 1'b0, 1'b1));
		queue_item(make_item(KIND_MARK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_MARK, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0));
		queue_item(make_item(KIND_ADD, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		queue_item(make_item(KIND_WRITE, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_WRITE, 8'h01, 8'h02, 8'hFF, 1'b0, 1'b0));
		queue_item(make_item(KIND_WRITE, 8'h03, 8'h01, 8'h10, 1'b0, 1'b0));
		queue_item(make_item(KIND_WRITE, 8'h00, 8'hFF, 8'h10, 1'b0, 1'b0));
		queue_item(make_item(KIND_WRITE, 8'hFF, 8'hFF, 8'h80, 1'b0, 1'b0));
		queue_item(make_item(KIND_MARK, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		queue_item(make_item(KIND_END, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
			queue_item(make_item(3'(k), 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
		queue_item(make_item(KIND_FEED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));

		// The start-state write below lands with a string still in progress.
		wait_idle();
		write_start(8'h01);
		queue_random(700);

		wait_idle();
		write_start(8'hFF);
		queue_random(60);

		wait_idle();
		while (built < STATE_LIMIT)
			queue_item(make_item(KIND_ADD, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0));
		repeat (3)
			queue_item(make_item(KIND_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));

		wait_idle();
		write_start(8'($urandom_range(1, 254)));
		pick_symbol_set();
		hold_req = 1'b1;
		queue_random(700);

		wait_idle();
		write_start(8'hFF);
		pick_symbol_set();
		calm = 1'b1;
		queue_random(400);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Checked %0d item transactions and %0d result transactions, %0d long holds.",
			sb.n_items, sb.n_results, holds_done);
		$display("Strings finished: %0d (%0d accepted); range errors %0d, table full %0d.",
			sb.n_matches, sb.n_accepts, sb.n_range, sb.n_full);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
